>>> rtl/scd_pkg.sv
// Shared types, key codes and ASCII lookup tables for the scan code decoder.
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_CHAR = 2'd1,
        EV_ESC  = 2'd2,
        EV_CTRL = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic num_lock;
        logic caps_lock;
        logic shift;
        logic alt;
        logic ctrl;
    } mod_flags_t;

    localparam logic [7:0] BYTE_EXT_PREFIX = 8'hE0;
    localparam logic [6:0] KEY_ESC         = 7'h01;
    localparam logic [6:0] KEY_CTRL        = 7'h1D;
    localparam logic [6:0] KEY_ALT         = 7'h38;
    localparam logic [6:0] KEY_LSHIFT      = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT      = 7'h36;
    localparam logic [6:0] KEY_LOCK_CAPS   = 7'h3A;
    localparam logic [6:0] KEY_NUM         = 7'h45;
    localparam logic [6:0] ROM_DEPTH       = 7'd63;

    function automatic logic [6:0] rom_plain(input logic [5:0] idx);
        logic [6:0] c;
        case (idx)
            6'd2:    c = 7'h31;
            6'd3:    c = 7'h32;
            6'd4:    c = 7'h33;
            6'd5:    c = 7'h34;
            6'd6:    c = 7'h35;
            6'd7:    c = 7'h36;
            6'd8:    c = 7'h37;
            6'd9:    c = 7'h38;
            6'd10:   c = 7'h39;
            6'd11:   c = 7'h30;
            6'd12:   c = 7'h2D;
            6'd13:   c = 7'h3D;
            6'd14:   c = 7'h08;
            6'd15:   c = 7'h09;
            6'd16:   c = 7'h71;
            6'd17:   c = 7'h77;
            6'd18:   c = 7'h65;
            6'd19:   c = 7'h72;
            6'd20:   c = 7'h74;
            6'd21:   c = 7'h79;
            6'd22:   c = 7'h75;
            6'd23:   c = 7'h69;
            6'd24:   c = 7'h6F;
            6'd25:   c = 7'h70;
            6'd26:   c = 7'h5B;
            6'd27:   c = 7'h5D;
            6'd28:   c = 7'h0A;
            6'd30:   c = 7'h61;
            6'd31:   c = 7'h73;
            6'd32:   c = 7'h64;
            6'd33:   c = 7'h66;
            6'd34:   c = 7'h67;
            6'd35:   c = 7'h68;
            6'd36:   c = 7'h6A;
            6'd37:   c = 7'h6B;
            6'd38:   c = 7'h6C;
            6'd39:   c = 7'h3B;
            6'd40:   c = 7'h27;
            6'd41:   c = 7'h60;
            6'd43:   c = 7'h5C;
            6'd44:   c = 7'h7A;
            6'd45:   c = 7'h78;
            6'd46:   c = 7'h63;
            6'd47:   c = 7'h76;
            6'd48:   c = 7'h62;
            6'd49:   c = 7'h6E;
            6'd50:   c = 7'h6D;
            6'd51:   c = 7'h2C;
            6'd52:   c = 7'h2E;
            6'd53:   c = 7'h2F;
            6'd55:   c = 7'h2A;
            6'd57:   c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] rom_upper(input logic [5:0] idx);
        logic [6:0] c;
        case (idx)
            6'd2:    c = 7'h21;
            6'd3:    c = 7'h40;
            6'd4:    c = 7'h23;
            6'd5:    c = 7'h24;
            6'd6:    c = 7'h25;
            6'd7:    c = 7'h5E;
            6'd8:    c = 7'h26;
            6'd9:    c = 7'h2A;
            6'd10:   c = 7'h28;
            6'd11:   c = 7'h29;
            6'd12:   c = 7'h5F;
            6'd13:   c = 7'h2B;
            6'd14:   c = 7'h08;
            6'd15:   c = 7'h09;
            6'd16:   c = 7'h51;
            6'd17:   c = 7'h57;
            6'd18:   c = 7'h45;
            6'd19:   c = 7'h52;
            6'd20:   c = 7'h54;
            6'd21:   c = 7'h59;
            6'd22:   c = 7'h55;
            6'd23:   c = 7'h49;
            6'd24:   c = 7'h4F;
            6'd25:   c = 7'h50;
            6'd26:   c = 7'h7B;
            6'd27:   c = 7'h7D;
            6'd28:   c = 7'h0A;
            6'd30:   c = 7'h41;
            6'd31:   c = 7'h53;
            6'd32:   c = 7'h44;
            6'd33:   c = 7'h46;
            6'd34:   c = 7'h47;
            6'd35:   c = 7'h48;
            6'd36:   c = 7'h4A;
            6'd37:   c = 7'h4B;
            6'd38:   c = 7'h4C;
            6'd39:   c = 7'h3A;
            6'd40:   c = 7'h22;
            6'd41:   c = 7'h7E;
            6'd43:   c = 7'h7C;
            6'd44:   c = 7'h5A;
            6'd45:   c = 7'h58;
            6'd46:   c = 7'h43;
            6'd47:   c = 7'h56;
            6'd48:   c = 7'h42;
            6'd49:   c = 7'h4E;
            6'd50:   c = 7'h4D;
            6'd51:   c = 7'h3C;
            6'd52:   c = 7'h3E;
            6'd53:   c = 7'h3F;
            6'd55:   c = 7'h2A;
            6'd57:   c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/scd_decode.sv
// Combinational decode of one scan byte against the current modifier flags.
`timescale 1ns / 1ps
`default_nettype none

module scd_decode (
    input  wire logic [7:0]          scan_byte,
    input  wire scd_pkg::mod_flags_t flags,
    output scd_pkg::mod_flags_t      flags_next,
    output scd_pkg::event_kind_t     kind,
    output logic [6:0]               ch
);

    logic [6:0] key;
    logic       released;
    logic [6:0] plain;
    logic [6:0] upper;
    logic       letter;

    assign key      = scan_byte[6:0];
    assign released = scan_byte[7];
    assign plain    = scd_pkg::rom_plain(key[5:0]);
    assign upper    = scd_pkg::rom_upper(key[5:0]);
    assign letter   = plain inside {[7'h61:7'h7A]};

    always_comb
    begin
        flags_next = flags;
        kind       = scd_pkg::EV_NONE;
        ch         = 7'h00;
        if (scan_byte == scd_pkg::BYTE_EXT_PREFIX)
        begin
            kind = scd_pkg::EV_NONE;
        end
        else if (key == scd_pkg::KEY_ESC)
        begin
            kind = scd_pkg::EV_ESC;
        end
        else if (key == scd_pkg::KEY_CTRL)
        begin
            flags_next.ctrl = !released;
        end
        else if (key == scd_pkg::KEY_ALT)
        begin
            flags_next.alt = !released;
        end
        else if (key == scd_pkg::KEY_LSHIFT || key == scd_pkg::KEY_RSHIFT)
        begin
            flags_next.shift = !released;
        end
        else if (key == scd_pkg::KEY_LOCK_CAPS)
        begin
            if (!released)
            begin
                flags_next.caps_lock = !flags.caps_lock;
            end
        end
        else if (key == scd_pkg::KEY_NUM)
        begin
            if (!released)
            begin
                flags_next.num_lock = !flags.num_lock;
            end
        end
        else if (!released && key < scd_pkg::ROM_DEPTH)
        begin
            if (flags.shift != (flags.caps_lock && letter))
            begin
                ch   = upper;
                kind = (upper != 7'h00) ? scd_pkg::EV_CHAR : scd_pkg::EV_NONE;
            end
            else if (flags.ctrl)
            begin
                ch   = plain;
                kind = scd_pkg::EV_CTRL;
            end
            else
            begin
                ch   = plain;
                kind = (plain != 7'h00) ? scd_pkg::EV_CHAR : scd_pkg::EV_NONE;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/scancode_to_ascii_decoder.sv
// Scan code set 1 decoder: input register, decode logic, result register.
// A transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle if not stalled; the modifier flags
// update as an item moves from the input register into the result register.
// Reset: asynchronous, active low; clears the valid bits and modifier flags.
`timescale 1ns / 1ps
`default_nettype none

module scancode_to_ascii_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] scan_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      event_kind,
    output logic [6:0]      ascii_char,
    output logic            ctrl_on,
    output logic            alt_on,
    output logic            shift_on,
    output logic            caps_lock_on,
    output logic            num_lock_on
);

    logic                 in_valid_reg;
    logic [7:0]           byte_reg;
    logic                 out_valid_reg;
    scd_pkg::event_kind_t kind_reg;
    logic [6:0]           char_reg;
    scd_pkg::mod_flags_t  flags_reg;
    scd_pkg::mod_flags_t  flags_next;
    scd_pkg::event_kind_t kind_next;
    logic [6:0]           char_next;
    logic                 advance;
    logic                 in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    scd_decode u_decode (
        .scan_byte  (byte_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .kind       (kind_next),
        .ch         (char_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= scan_byte;
        end
        if (advance)
        begin
            kind_reg <= kind_next;
            char_reg <= char_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign ascii_char   = char_reg;
    assign ctrl_on      = flags_reg.ctrl;
    assign alt_on       = flags_reg.alt;
    assign shift_on     = flags_reg.shift;
    assign caps_lock_on = flags_reg.caps_lock;
    assign num_lock_on  = flags_reg.num_lock;

endmodule

`default_nettype wire
